@@ hw/rtl/cpts_pkg.sv @@
// Shared types and constants for the counter/priority task scheduler.
// Holds the slot table entry layout, the command codes and the counter limits.
// No dependencies.
`default_nettype none

package cpts_pkg;

    localparam int MODE_W = 3;
    localparam int SLOT_W = 6;
    localparam int PRIO_W = 8;
    localparam int CNT_W  = 16;
    localparam int HOLD_W = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 3'd0,
        MODE_YIELD   = 3'd1,
        MODE_LOAD    = 3'd2,
        MODE_REMOVE  = 3'd3,
        MODE_HOLD    = 3'd4,
        MODE_RELEASE = 3'd5
    } cpts_mode_t;

    // One slot of the task table as it sits in the memory.
    typedef struct packed {
        logic                    present;
        logic                    running;
        logic [PRIO_W-1:0]       prio;
        logic signed [CNT_W-1:0] count;
        logic [HOLD_W-1:0]       hold;
    } cpts_entry_t;

    localparam logic signed [CNT_W-1:0] CNT_MIN  = 16'sh8000;
    localparam logic signed [CNT_W-1:0] CNT_NONE = -16'sd1;
    localparam logic signed [CNT_W-1:0] CNT_ZERO = 16'sd0;
    localparam logic signed [CNT_W-1:0] CNT_ONE  = 16'sd1;
    localparam logic [HOLD_W-1:0]       HOLD_MAX = 8'hFF;
    localparam logic [HOLD_W-1:0]       HOLD_ONE = 8'h01;
    localparam logic [HOLD_W-1:0]       HOLD_ZERO = 8'h00;

endpackage

`default_nettype wire

@@ hw/rtl/counter_priority_task_scheduler.sv @@
// Counter/priority task scheduler: slot table memory, command sequencer and result register.
// Depends on cpts_pkg.
`default_nettype none

// Each input word is one command (tick, yield, load, remove, preempt hold or release) and
// yields exactly one result word with the current slot, the previous slot, a switch flag and
// a stuck flag. All slot state lives in one single-port-read, single-port-write table memory
// of TASK_SLOTS entries; one flip-flop per entry marks whether it has been written, and an
// unwritten entry reads as its reset value, so there is no clearing pass after reset.
// Load, remove, hold, release and a tick that does not expire read, modify and write back
// one entry. A tick that expires, or a yield, also scans the table, one entry per cycle
// through the memory read port; when the best counter is zero, every present counter is
// recomputed and the table scanned again. A new command
// is taken while a finished result still waits on out_stall.
module counter_priority_task_scheduler #(
    parameter int TASK_SLOTS = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [cpts_pkg::MODE_W-1:0]       mode,
    input  wire logic [cpts_pkg::SLOT_W-1:0]       slot,
    input  wire logic                              runnable,
    input  wire logic [cpts_pkg::PRIO_W-1:0]       prio,
    input  wire logic signed [cpts_pkg::CNT_W-1:0] slice,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [cpts_pkg::SLOT_W-1:0]            current_slot,
    output logic                                   switched,
    output logic [cpts_pkg::SLOT_W-1:0]            from_slot,
    output logic                                   stuck
);

    import cpts_pkg::*;

    localparam int              IDX_W = $clog2(TASK_SLOTS);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TASK_SLOTS - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_MOD    = 6'b000100,
        S_SCAN   = 6'b001000,
        S_RECALC = 6'b010000,
        S_DONE   = 6'b100000
    } cpts_state_t;

    cpts_state_t state_reg, state_next;

    // Slot table memory and its read pipeline.
    cpts_entry_t             mem [TASK_SLOTS];
    cpts_entry_t             mem_q_reg;
    logic [TASK_SLOTS-1:0]   written_reg;
    logic                    rdv_reg;
    logic [IDX_W-1:0]        rd_addr_reg;
    logic                    entry_written_reg;

    logic                    mem_re;
    logic [IDX_W-1:0]        mem_raddr;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    cpts_entry_t             mem_wdata;

    // Latched command.
    logic [MODE_W-1:0]       mode_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic                    run_reg;
    logic [PRIO_W-1:0]       prio_reg;
    logic signed [CNT_W-1:0] slice_reg;
    logic [IDX_W-1:0]        from_reg;

    // Sequencer state.
    logic [IDX_W-1:0]        cur_reg, cur_next;
    logic [IDX_W-1:0]        iss_reg, iss_next;
    logic                    iss_done_reg, iss_done_next;
    logic                    pass2_reg, pass2_next;
    logic signed [CNT_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0]        win_reg, win_next;
    logic                    stuck_reg, stuck_next;

    // Result register.
    logic                    out_valid_reg;
    logic [SLOT_W-1:0]       current_slot_reg;
    logic                    switched_reg;
    logic [SLOT_W-1:0]       from_slot_reg;
    logic                    stuck_out_reg;

    logic                    accept;
    logic                    out_free;
    cpts_entry_t             ent;
    logic                    slot_ok;
    logic [IDX_W-1:0]        tgt_addr;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign slot_ok  = (32'(slot_reg) < TASK_SLOTS);
    assign tgt_addr = ((mode_reg == MODE_LOAD) || (mode_reg == MODE_REMOVE))
                      ? IDX_W'(slot_reg) : cur_reg;

    // An entry that was never written reads as its reset value.
    always_comb
    begin
        if (entry_written_reg)
        begin
            ent = mem_q_reg;
        end
        else
        begin
            ent.present = (rd_addr_reg == '0);
            ent.running = (rd_addr_reg == '0);
            ent.prio    = '0;
            ent.count   = CNT_ZERO;
            ent.hold    = HOLD_ZERO;
        end
    end

    always_comb
    begin
        logic signed [CNT_W-1:0] dec;
        logic signed [CNT_W-1:0] half;
        logic signed [CNT_W-1:0] cand_best;
        logic [IDX_W-1:0]        cand_win;
        cpts_entry_t             ent_w;

        state_next    = state_reg;
        cur_next      = cur_reg;
        iss_next      = iss_reg;
        iss_done_next = iss_done_reg;
        pass2_next    = pass2_reg;
        best_next     = best_reg;
        win_next      = win_reg;
        stuck_next    = stuck_reg;
        mem_re        = 1'b0;
        mem_raddr     = iss_reg;
        mem_we        = 1'b0;
        mem_waddr     = tgt_addr;
        ent_w         = ent;
        dec           = (ent.count != CNT_MIN) ? (ent.count - CNT_ONE) : ent.count;
        half          = ent.count >>> 1;
        cand_best     = best_reg;
        cand_win      = win_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    stuck_next = 1'b0;
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                mem_re     = 1'b1;
                mem_raddr  = tgt_addr;
                state_next = S_MOD;
            end

            S_MOD:
            begin
                state_next = S_DONE;
                case (mode_reg)
                    MODE_TICK:
                    begin
                        mem_we = 1'b1;
                        if ((dec > CNT_ZERO) || (ent.hold != HOLD_ZERO))
                        begin
                            ent_w.count = dec;
                        end
                        else
                        begin
                            ent_w.count = CNT_ZERO;
                            state_next  = S_SCAN;
                        end
                    end
                    MODE_YIELD:
                    begin
                        mem_we      = 1'b1;
                        ent_w.count = CNT_ZERO;
                        state_next  = S_SCAN;
                    end
                    MODE_LOAD:
                    begin
                        mem_we        = slot_ok;
                        ent_w.present = 1'b1;
                        ent_w.running = run_reg;
                        ent_w.prio    = prio_reg;
                        ent_w.count   = slice_reg;
                        ent_w.hold    = HOLD_ZERO;
                    end
                    MODE_REMOVE:
                    begin
                        mem_we        = slot_ok;
                        ent_w.present = 1'b0;
                        ent_w.running = 1'b0;
                    end
                    MODE_HOLD:
                    begin
                        mem_we = 1'b1;
                        if (ent.hold != HOLD_MAX)
                        begin
                            ent_w.hold = ent.hold + HOLD_ONE;
                        end
                    end
                    MODE_RELEASE:
                    begin
                        mem_we = 1'b1;
                        if (ent.hold != HOLD_ZERO)
                        begin
                            ent_w.hold = ent.hold - HOLD_ONE;
                        end
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
                if (state_next == S_SCAN)
                begin
                    iss_next      = '0;
                    iss_done_next = 1'b0;
                    best_next     = CNT_NONE;
                    win_next      = '0;
                    pass2_next    = 1'b0;
                end
            end

            S_SCAN:
            begin
                mem_re = !iss_done_reg;
                if (!iss_done_reg)
                begin
                    iss_next = iss_reg + 1'b1;
                    if (iss_reg == LAST)
                    begin
                        iss_done_next = 1'b1;
                    end
                end
                if (rdv_reg)
                begin
                    // Strictly greater keeps the lowest index on ties.
                    if (ent.present && ent.running && (ent.count > best_reg))
                    begin
                        cand_best = ent.count;
                        cand_win  = rd_addr_reg;
                    end
                    best_next = cand_best;
                    win_next  = cand_win;
                    if (rd_addr_reg == LAST)
                    begin
                        if (cand_best == CNT_ZERO)
                        begin
                            if (pass2_reg)
                            begin
                                stuck_next = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                pass2_next    = 1'b1;
                                iss_next      = '0;
                                iss_done_next = 1'b0;
                                state_next    = S_RECALC;
                            end
                        end
                        else
                        begin
                            cur_next   = cand_win;
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_RECALC:
            begin
                mem_re = !iss_done_reg;
                if (!iss_done_reg)
                begin
                    iss_next = iss_reg + 1'b1;
                    if (iss_reg == LAST)
                    begin
                        iss_done_next = 1'b1;
                    end
                end
                // Write-back of entry i overlaps the read of entry i+1, never the same entry.
                mem_waddr   = rd_addr_reg;
                ent_w.count = half + $signed({{(CNT_W-PRIO_W){1'b0}}, ent.prio});
                if (rdv_reg)
                begin
                    mem_we = ent.present;
                    if (rd_addr_reg == LAST)
                    begin
                        iss_next      = '0;
                        iss_done_next = 1'b0;
                        best_next     = CNT_NONE;
                        win_next      = '0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        mem_wdata = ent_w;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg       <= mem_raddr;
        entry_written_reg <= written_reg[mem_raddr];
        if (accept)
        begin
            mode_reg  <= mode;
            slot_reg  <= slot;
            run_reg   <= runnable;
            prio_reg  <= prio;
            slice_reg <= slice;
            from_reg  <= cur_reg;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            current_slot_reg <= SLOT_W'(cur_reg);
            switched_reg     <= (cur_reg != from_reg);
            from_slot_reg    <= SLOT_W'(from_reg);
            stuck_out_reg    <= stuck_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            written_reg   <= '0;
            rdv_reg       <= 1'b0;
            cur_reg       <= '0;
            iss_reg       <= '0;
            iss_done_reg  <= 1'b0;
            pass2_reg     <= 1'b0;
            best_reg      <= CNT_NONE;
            win_reg       <= '0;
            stuck_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rdv_reg      <= mem_re;
            cur_reg      <= cur_next;
            iss_reg      <= iss_next;
            iss_done_reg <= iss_done_next;
            pass2_reg    <= pass2_next;
            best_reg     <= best_next;
            win_reg      <= win_next;
            stuck_reg    <= stuck_next;
            if (mem_we)
            begin
                written_reg[mem_waddr] <= 1'b1;
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign current_slot = current_slot_reg;
    assign switched     = switched_reg;
    assign from_slot    = from_slot_reg;
    assign stuck        = stuck_out_reg;

endmodule

`default_nettype wire

@@ tb/counter_priority_task_scheduler_test.sv @@
// Self-checking testbench for counter_priority_task_scheduler: directed and random command words
// checked against an in-file scheduler predictor, under random and long output stalls.
// Depends on cpts_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module counter_priority_task_scheduler_test;
    import cpts_pkg::*;

    localparam int TASK_SLOTS    = 64;
    localparam int CNT_TOP       = 32767;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int TAIL_CYCLES   = 3 * TASK_SLOTS + 60;
    localparam int RANDOM_WORDS  = 350;

    // Command codes the block decodes as no-ops.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct {
        logic [SLOT_W-1:0] current_slot;
        logic              switched;
        logic [SLOT_W-1:0] from_slot;
        logic              stuck;
    } sched_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [MODE_W-1:0]       mode = '0;
    logic [SLOT_W-1:0]       slot = '0;
    logic                    runnable = 1'b0;
    logic [PRIO_W-1:0]       prio = '0;
    logic signed [CNT_W-1:0] slice = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [SLOT_W-1:0]       current_slot;
    logic                    switched;
    logic [SLOT_W-1:0]       from_slot;
    logic                    stuck;

    // Predicted copy of the slot table.
    logic              tbl_present [TASK_SLOTS];
    logic              tbl_running [TASK_SLOTS];
    logic [PRIO_W-1:0] tbl_prio    [TASK_SLOTS];
    int                tbl_count   [TASK_SLOTS];
    logic [HOLD_W-1:0] tbl_hold    [TASK_SLOTS];
    logic [SLOT_W-1:0] cur_slot;

    sched_result_t pending_results[$];
    int            error_count = 0;
    int            send_idle_pct = 10;
    int            recv_idle_pct = 61;
    int            recv_hold_cycles = 0;
    int unsigned   cycles_run = 0;

    counter_priority_task_scheduler #(
        .TASK_SLOTS(TASK_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .slot(slot),
        .runnable(runnable),
        .prio(prio),
        .slice(slice),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .current_slot(current_slot),
        .switched(switched),
        .from_slot(from_slot),
        .stuck(stuck)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Running slot with the largest non-negative counter; lowest index wins ties.
    function automatic logic [SLOT_W-1:0] best_slot(output int best_count);
        int                c;
        logic [SLOT_W-1:0] win;
        c = -1;
        win = '0;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            if (tbl_present[i] && tbl_running[i] && tbl_count[i] > c)
            begin
                c = tbl_count[i];
                win = SLOT_W'(i);
            end
        end
        best_count = c;
        return win;
    endfunction

    // Returns 1 when even the recompute pass leaves the best running counter at zero.
    function automatic logic reschedule();
        int                best;
        int                v;
        logic [SLOT_W-1:0] win;
        win = best_slot(best);
        if (best == 0)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                if (tbl_present[i])
                begin
                    v = (tbl_count[i] >>> 1) + int'(tbl_prio[i]);
                    tbl_count[i] = (v > CNT_TOP) ? CNT_TOP : v;
                end
            end
            win = best_slot(best);
            if (best == 0)
                return 1'b1;
        end
        cur_slot = win;
        return 1'b0;
    endfunction

    function automatic sched_result_t apply_command(input logic [MODE_W-1:0] cmd,
                                                    input logic [SLOT_W-1:0] addr,
                                                    input logic run_bit,
                                                    input logic [PRIO_W-1:0] pri,
                                                    input logic signed [CNT_W-1:0] cnt_init);
        sched_result_t     res;
        logic [SLOT_W-1:0] c;
        logic              hung;
        c = cur_slot;
        hung = 1'b0;
        case (cmd)
            MODE_TICK:
            begin
                if (tbl_count[c] > int'(CNT_MIN))
                    tbl_count[c]--;
                if (tbl_count[c] <= 0 && tbl_hold[c] == HOLD_ZERO)
                begin
                    tbl_count[c] = 0;
                    hung = reschedule();
                end
            end
            MODE_YIELD:
            begin
                tbl_count[c] = 0;
                hung = reschedule();
            end
            MODE_LOAD:
            begin
                tbl_present[addr] = 1'b1;
                tbl_running[addr] = run_bit;
                tbl_prio[addr] = pri;
                tbl_count[addr] = int'(cnt_init);
                tbl_hold[addr] = HOLD_ZERO;
            end
            MODE_REMOVE:
            begin
                tbl_present[addr] = 1'b0;
                tbl_running[addr] = 1'b0;
            end
            MODE_HOLD:
            begin
                if (tbl_hold[c] != HOLD_MAX)
                    tbl_hold[c]++;
            end
            MODE_RELEASE:
            begin
                if (tbl_hold[c] != HOLD_ZERO)
                    tbl_hold[c]--;
            end
            default:
            begin
            end
        endcase
        res.current_slot = cur_slot;
        res.switched = (cur_slot != c);
        res.from_slot = c;
        res.stuck = hung;
        return res;
    endfunction

    // Offers one word and returns at the edge that takes it. Valid stays high on return so
    // that a following word can be presented without a bubble.
    task automatic send_word(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] s,
                             input logic r, input logic [PRIO_W-1:0] p,
                             input logic signed [CNT_W-1:0] sl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        slot <= s;
        runnable <= r;
        prio <= p;
        slice <= sl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(apply_command(m, s, r, p, sl));
    endtask

    // Commands that ignore the slot fields still get random values there.
    task automatic send_cmd(input logic [MODE_W-1:0] m);
        send_word(m, SLOT_W'($urandom), 1'($urandom), PRIO_W'($urandom), CNT_W'($urandom));
    endtask

    task automatic send_load(input logic [SLOT_W-1:0] s, input logic r,
                             input logic [PRIO_W-1:0] p, input logic signed [CNT_W-1:0] sl);
        send_word(MODE_LOAD, s, r, p, sl);
    endtask

    task automatic send_remove(input logic [SLOT_W-1:0] s);
        send_word(MODE_REMOVE, s, 1'($urandom), PRIO_W'($urandom), CNT_W'($urandom));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly a small working set of slots with short slices, so that ticks expire often and
    // the recompute pass is reached; the rest is noise over the whole field ranges.
    task automatic send_random_word();
        int                      pick;
        logic [SLOT_W-1:0]       s;
        logic [PRIO_W-1:0]       p;
        logic signed [CNT_W-1:0] sl;
        pick = $urandom_range(99);
        s = ($urandom_range(3) == 0) ? SLOT_W'($urandom_range(63)) : SLOT_W'($urandom_range(7));
        p = ($urandom_range(1) == 0) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(3));
        case ($urandom_range(3))
            0: sl = CNT_W'($urandom_range(12));
            1: sl = -CNT_W'($urandom_range(12));
            2: sl = CNT_W'($urandom_range(300));
            default: sl = CNT_W'($urandom);
        endcase
        if (pick < 25)
            send_load(s, $urandom_range(3) != 0, p, sl);
        else if (pick < 60)
            send_cmd(MODE_TICK);
        else if (pick < 70)
            send_cmd(MODE_YIELD);
        else if (pick < 78)
            send_remove(s);
        else if (pick < 86)
            send_cmd(MODE_HOLD);
        else if (pick < 94)
            send_cmd(MODE_RELEASE);
        else if (pick < 97)
            send_cmd(($urandom_range(1) == 0) ? MODE_SPARE_LO : MODE_SPARE_HI);
        else
            send_word(MODE_W'($urandom), SLOT_W'($urandom), 1'($urandom), PRIO_W'($urandom),
                      CNT_W'($urandom));
    endtask

    // Slot 0 alone with a zero counter and zero priority: the recompute cannot help.
    task automatic test_tick_after_reset();
        send_cmd(MODE_TICK);
    endtask

    task automatic test_load_extremes();
        send_load(6'd63, 1'b1, 8'd255, 16'sd32767);
        send_load(6'd1, 1'b1, 8'd0, CNT_MIN);
        send_load(6'd2, 1'b0, 8'd128, 16'sd100);
        send_cmd(MODE_YIELD);
        send_cmd(MODE_TICK);
    endtask

    // Reload the current slot at the bottom of the range, then tick it while held.
    task automatic test_held_tick();
        send_load(cur_slot, 1'b1, 8'd255, CNT_MIN);
        send_cmd(MODE_HOLD);
        send_cmd(MODE_TICK);
        send_cmd(MODE_RELEASE);
        send_cmd(MODE_RELEASE);
        send_cmd(MODE_TICK);
    endtask

    // The removed current slot stays current; with nothing runnable slot 0 is picked even
    // though it is gone too.
    task automatic test_remove_current();
        send_remove(cur_slot);
        send_cmd(MODE_TICK);
        send_cmd(MODE_YIELD);
        send_remove(6'd0);
        send_cmd(MODE_YIELD);
        send_cmd(MODE_TICK);
    endtask

    task automatic test_unused_modes();
        send_cmd(MODE_SPARE_LO);
        send_cmd(MODE_SPARE_HI);
    endtask

    task automatic test_hold_limits();
        send_load(cur_slot, 1'b1, PRIO_W'($urandom), 16'sd3);
        repeat (260)
            send_cmd(MODE_HOLD);
        repeat (4)
            send_cmd(MODE_TICK);
        repeat (260)
            send_cmd(MODE_RELEASE);
        send_cmd(MODE_TICK);
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_output_backpressure();
        recv_hold_cycles = 400;
        repeat (3)
            send_cmd(MODE_HOLD);
        send_cmd(MODE_YIELD);
        repeat (3)
            send_cmd(MODE_RELEASE);
        repeat (4)
            send_random_word();
    endtask

    task automatic test_random_traffic(input int words);
        repeat (words)
            send_random_word();
        drain_results();
    endtask

    always @(posedge clk)
    begin
        if (recv_hold_cycles > 0)
        begin
            recv_hold_cycles = recv_hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        sched_result_t want;
        if (out_valid === 1'b1 && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected: current_slot %0d", current_slot);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (current_slot !== want.current_slot)
                begin
                    $error("current_slot: expected %0d, got %0d", want.current_slot,
                           current_slot);
                    error_count++;
                end
                if (switched !== want.switched)
                begin
                    $error("switched: expected %0d, got %0d", want.switched, switched);
                    error_count++;
                end
                if (from_slot !== want.from_slot)
                begin
                    $error("from_slot: expected %0d, got %0d", want.from_slot, from_slot);
                    error_count++;
                end
                if (stuck !== want.stuck)
                begin
                    $error("stuck: expected %0d, got %0d", want.stuck, stuck);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            tbl_present[i] = (i == 0);
            tbl_running[i] = (i == 0);
            tbl_prio[i] = '0;
            tbl_count[i] = 0;
            tbl_hold[i] = HOLD_ZERO;
        end
        cur_slot = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 10;
        recv_idle_pct = 61;
        test_tick_after_reset();
        test_load_extremes();
        test_held_tick();
        test_remove_current();
        test_unused_modes();
        test_random_traffic(RANDOM_WORDS);

        send_idle_pct = 61;
        recv_idle_pct = 10;
        test_random_traffic(RANDOM_WORDS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_hold_limits();
        test_output_backpressure();
        test_random_traffic(RANDOM_WORDS);

        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/cpts_pkg.sv
hw/rtl/counter_priority_task_scheduler.sv
tb/counter_priority_task_scheduler_test.sv
